@@ rtl/pmfb_pkg.sv @@
// Shared constants for the page map and frame bitmap unit.
// Holds sizes, field widths, operation and status codes.
// No dependencies.
package pmfb_pkg;

  // Address space sizes.
  localparam int unsigned VIRTUAL_PAGES   = 1024;
  localparam int unsigned PHYSICAL_FRAMES = 1024;

  // Field widths of the channels.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned PAGE_W   = 10;
  localparam int unsigned FRAME_W  = 10;
  localparam int unsigned STATUS_W = 2;

  // Bitmaps are held as words of WORD_W bits.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = $clog2(WORD_W);

  localparam int unsigned VP_WORDS  = (VIRTUAL_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned FR_WORDS  = (PHYSICAL_FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned VP_WAW    = (VP_WORDS > 1) ? $clog2(VP_WORDS) : 1;
  localparam int unsigned FR_WAW    = (FR_WORDS > 1) ? $clog2(FR_WORDS) : 1;
  localparam int unsigned CLR_WORDS = (VP_WORDS > FR_WORDS) ? VP_WORDS : FR_WORDS;
  localparam int unsigned CLR_W     = (CLR_WORDS > 1) ? $clog2(CLR_WORDS) : 1;
  localparam int unsigned PS_AW     = $clog2(VIRTUAL_PAGES);

  // Valid frame bits in the last frame bitmap word.
  localparam int unsigned FR_TAIL = PHYSICAL_FRAMES - (FR_WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - FR_TAIL);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_MAP   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_UNMAP = OP_W'(1);
  localparam logic [OP_W-1:0] OP_FIND  = OP_W'(2);
  localparam logic [OP_W-1:0] OP_USE   = OP_W'(3);
  localparam logic [OP_W-1:0] OP_FREE  = OP_W'(4);

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_NONE_FREE = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_ABSENT    = STATUS_W'(2);

endpackage

@@ rtl/pmfb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pmfb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/page_map_and_frame_bitmap_unit.sv @@
// Page map and frame bitmap unit: top level with the operation sequencer.
// Depends on pmfb_pkg and pmfb_ram.
//
// Usage:
// The input channel (in_valid_i / in_ready_o) carries one operation per
// transfer: op_i, virtual_page_i and frame_number_i. The output channel
// (out_valid_o / out_ready_i) returns exactly one result per operation:
// result_frame_o and status_o.
// Each operation runs alone through a small sequencer around three RAMs
// (page map, present bitmap, frame bitmap); in_ready_o is high only when
// the sequencer is idle. Every operation but find reads the RAMs and
// then executes; unmap then reads and clears the old frame's bit in a
// second pass. The find search reads one 32-bit frame bitmap word per
// cycle from the single read port and scans 1 to 32 words. After reset
// a clearing pass over the 32 bitmap words zeroes both bitmaps; no
// input transfer is taken during it. The page map itself is not cleared.
// A finished result sits in an output register; if the receiver stalls,
// the next operation may still be taken and completed, and then waits
// until the output register is free.
module page_map_and_frame_bitmap_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pmfb_pkg::OP_W-1:0]     op_i,
  input  logic [pmfb_pkg::PAGE_W-1:0]   virtual_page_i,
  input  logic [pmfb_pkg::FRAME_W-1:0]  frame_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pmfb_pkg::FRAME_W-1:0]  result_frame_o,
  output logic [pmfb_pkg::STATUS_W-1:0] status_o
);
  import pmfb_pkg::*;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_EX   = 8'b0000_1000,
    S_RD2  = 8'b0001_0000,
    S_EX2  = 8'b0010_0000,
    S_SCAN = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  localparam logic [FR_WAW-1:0] FR_LAST  = FR_WAW'(FR_WORDS - 1);
  localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(CLR_WORDS - 1);

  state_e state_q, state_d;

  logic [OP_W-1:0]     op_q;
  logic [PAGE_W-1:0]   vp_q;
  logic [FRAME_W-1:0]  fr_q;
  logic [FRAME_W-1:0]  old_q, old_d;
  logic [CLR_W-1:0]    clr_q, clr_d;
  logic [FR_WAW-1:0]   scan_q, scan_d;
  logic [FR_WAW-1:0]   chk_q, chk_d;
  logic                pend_q, pend_d;
  logic [FRAME_W-1:0]  res_q, res_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic                load_in;
  logic                load_out;

  logic                out_valid_q;
  logic [FRAME_W-1:0]  out_frame_q;
  logic [STATUS_W-1:0] out_status_q;

  // RAM ports.
  logic              f_we;
  logic [FR_WAW-1:0] f_waddr, f_raddr;
  logic [WORD_W-1:0] f_wdata, f_rdata;
  logic              p_we;
  logic [VP_WAW-1:0] p_waddr;
  logic [WORD_W-1:0] p_wdata, p_rdata;
  logic              g_we;
  logic [FRAME_W-1:0] g_rdata;

  // Address decode of the held operands.
  logic [31:0]       vp_ext, fr_ext, old_ext, clr_ext;
  logic              vp_ok, fr_ok, old_ok, clr_vp_ok, clr_fr_ok;
  logic [VP_WAW-1:0] vp_word, clr_vp;
  logic [FR_WAW-1:0] fr_word, old_word, clr_fr;
  logic [WORD_W-1:0] vp_mask, fr_mask, old_mask;
  logic [PS_AW-1:0]  ps_addr;

  assign vp_ext  = 32'(vp_q);
  assign fr_ext  = 32'(fr_q);
  assign old_ext = 32'(old_q);
  assign clr_ext = 32'(clr_q);

  assign vp_ok     = vp_ext < 32'(VIRTUAL_PAGES);
  assign fr_ok     = fr_ext < 32'(PHYSICAL_FRAMES);
  assign old_ok    = old_ext < 32'(PHYSICAL_FRAMES);
  assign clr_vp_ok = clr_ext < 32'(VP_WORDS);
  assign clr_fr_ok = clr_ext < 32'(FR_WORDS);

  assign vp_word  = vp_ext[BIT_W +: VP_WAW];
  assign fr_word  = fr_ext[BIT_W +: FR_WAW];
  assign old_word = old_ext[BIT_W +: FR_WAW];
  assign clr_vp   = clr_ext[VP_WAW-1:0];
  assign clr_fr   = clr_ext[FR_WAW-1:0];
  assign ps_addr  = vp_ext[PS_AW-1:0];

  assign vp_mask  = WORD_W'(1) << vp_q[BIT_W-1:0];
  assign fr_mask  = WORD_W'(1) << fr_q[BIT_W-1:0];
  assign old_mask = WORD_W'(1) << old_q[BIT_W-1:0];

  // Lowest clear bit of the scanned word; frames past the end count as used.
  logic [WORD_W-1:0]  scan_word;
  logic               free_hit;
  logic [BIT_W-1:0]   free_bit;
  logic [31:0]        found_ext;
  logic [FRAME_W-1:0] found_frame;

  assign scan_word = f_rdata | ~((chk_q == FR_LAST) ? TAIL_MASK : {WORD_W{1'b1}});

  always_comb begin
    free_hit = 1'b0;
    free_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!scan_word[i]) begin
        free_hit = 1'b1;
        free_bit = BIT_W'(i);
      end
    end
  end

  assign found_ext   = (32'(chk_q) << BIT_W) | 32'(free_bit);
  assign found_frame = found_ext[FRAME_W-1:0];

  // Sequencer: next state, RAM controls and working result.
  always_comb begin
    state_d  = state_q;
    old_d    = old_q;
    clr_d    = clr_q;
    scan_d   = scan_q;
    chk_d    = chk_q;
    pend_d   = pend_q;
    res_d    = res_q;
    st_d     = st_q;
    load_in  = 1'b0;
    load_out = 1'b0;
    f_we     = 1'b0;
    f_waddr  = fr_word;
    f_wdata  = f_rdata | fr_mask;
    f_raddr  = fr_word;
    p_we     = 1'b0;
    p_waddr  = vp_word;
    p_wdata  = p_rdata | vp_mask;
    g_we     = 1'b0;

    unique case (state_q)
      S_CLR: begin
        f_we    = clr_fr_ok;
        f_waddr = clr_fr;
        f_wdata = '0;
        p_we    = clr_vp_ok;
        p_waddr = clr_vp;
        p_wdata = '0;
        clr_d   = CLR_W'(clr_q + 1'b1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          res_d   = '0;
          st_d    = ST_DONE;
          scan_d  = '0;
          pend_d  = 1'b0;
          state_d = (op_i == OP_FIND) ? S_SCAN : S_RD;
        end
      end
      S_RD: begin
        state_d = S_EX;
      end
      S_EX: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_MAP: begin
            if (vp_ok && fr_ok) begin
              f_we = 1'b1;
              p_we = 1'b1;
              g_we = 1'b1;
            end
          end
          OP_UNMAP: begin
            if (vp_ok && ((p_rdata & vp_mask) != '0)) begin
              p_we    = 1'b1;
              p_wdata = p_rdata & ~vp_mask;
              old_d   = g_rdata;
              state_d = S_RD2;
            end else begin
              st_d = ST_ABSENT;
            end
          end
          OP_USE: begin
            f_we = fr_ok;
          end
          OP_FREE: begin
            f_we    = fr_ok;
            f_wdata = f_rdata & ~fr_mask;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RD2: begin
        f_raddr = old_word;
        state_d = S_EX2;
      end
      S_EX2: begin
        f_we    = old_ok;
        f_waddr = old_word;
        f_wdata = f_rdata & ~old_mask;
        res_d   = old_q;
        state_d = S_DONE;
      end
      S_SCAN: begin
        // Issue one word read per cycle and test the word read last cycle.
        f_raddr = scan_q;
        pend_d  = 1'b1;
        chk_d   = scan_q;
        if (scan_q != FR_LAST) begin
          scan_d = FR_WAW'(scan_q + 1'b1);
        end
        if (pend_q) begin
          if (free_hit) begin
            res_d   = found_frame;
            state_d = S_DONE;
          end else if (chk_q == FR_LAST) begin
            st_d    = ST_NONE_FREE;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operands, working values and the output register.
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      op_q <= op_i;
      vp_q <= virtual_page_i;
      fr_q <= frame_number_i;
    end
    old_q  <= old_d;
    scan_q <= scan_d;
    chk_q  <= chk_d;
    res_q  <= res_d;
    st_q   <= st_d;
    if (load_out) begin
      out_frame_q  <= res_q;
      out_status_q <= st_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_frame_o = out_frame_q;
  assign status_o       = out_status_q;

  // Frame bitmap, one bit per physical frame.
  pmfb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(FR_WORDS)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .raddr_i(f_raddr),
    .rdata_o(f_rdata)
  );

  // Present bitmap, one bit per virtual page.
  pmfb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(VP_WORDS)
  ) u_present_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(vp_word),
    .rdata_o(p_rdata)
  );

  // Page map, one frame number per virtual page.
  pmfb_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(VIRTUAL_PAGES)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (g_we),
    .waddr_i(ps_addr),
    .wdata_i(fr_q),
    .raddr_i(ps_addr),
    .rdata_o(g_rdata)
  );

`ifndef SYNTHESIS
  // An accepted operation drops in_ready_o and so holds off the next one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken back to back");

  // The free-frame search never modifies the frame bitmap.
  a_scan_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !f_we)
    else $error("frame bitmap written during search");

  // A page map write always comes with its present and frame bit updates.
  a_map_writes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_we |-> (p_we && f_we))
    else $error("page map written alone");

  // Failing operations report frame zero.
  a_fail_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_DONE)) |-> (result_frame_o == '0))
    else $error("failing result carries a frame");

  // A finished result waits while the output register is still occupied.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=>
      (state_q == S_DONE && out_valid_q))
    else $error("result overwrote a pending output");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for page_map_and_frame_bitmap_unit.
// It keeps its own copy of the page map and both bitmaps; results are checked against it or hand-written values.
// Depends on pmfb_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
  import pmfb_pkg::*;

  // Operation codes that the unit must ignore.
  localparam logic [OP_W-1:0] OP_RSVD_A = OP_W'(5);
  localparam logic [OP_W-1:0] OP_RSVD_B = OP_W'(6);
  localparam logic [OP_W-1:0] OP_RSVD_C = OP_W'(7);

  localparam int unsigned RANDOM_ROUNDS = 450;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    bit                 typed;
    result_t            want;
  } step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i;
  logic [PAGE_W-1:0]   virtual_page_i;
  logic [FRAME_W-1:0]  frame_number_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [FRAME_W-1:0]  result_frame_o;
  logic [STATUS_W-1:0] status_o;

  // Shadow copy of the unit's state.
  logic [FRAME_W-1:0] page_frame [VIRTUAL_PAGES];
  bit                 present_bits [VIRTUAL_PAGES];
  bit                 used_bits [PHYSICAL_FRAMES];
  logic [PAGE_W-1:0]  mapped_pages [$];

  // Results owed by the unit, oldest first.
  result_t     owed_results [$];
  int unsigned mismatches;
  bit          quiet;

  page_map_and_frame_bitmap_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .virtual_page_i (virtual_page_i),
    .frame_number_i (frame_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_frame_o (result_frame_o),
    .status_o       (status_o)
  );

  // Directed sequence; rows with typed set carry a hand-written result.
  step_t directed [] = '{
    '{OP_FIND,   10'd0,    10'd0,    1'b1, '{10'd0,    ST_DONE}},
    '{OP_UNMAP,  10'd0,    10'd0,    1'b1, '{10'd0,    ST_ABSENT}},
    '{OP_UNMAP,  10'd1023, 10'd1023, 1'b1, '{10'd0,    ST_ABSENT}},
    '{OP_MAP,    10'd0,    10'd0,    1'b1, '{10'd0,    ST_DONE}},
    '{OP_FIND,   10'd0,    10'd0,    1'b1, '{10'd1,    ST_DONE}},
    '{OP_MAP,    10'd1023, 10'd1023, 1'b1, '{10'd0,    ST_DONE}},
    '{OP_USE,    10'd0,    10'd1,    1'b1, '{10'd0,    ST_DONE}},
    '{OP_FIND,   10'd0,    10'd0,    1'b1, '{10'd2,    ST_DONE}},
    '{OP_MAP,    10'd0,    10'd5,    1'b1, '{10'd0,    ST_DONE}},
    '{OP_UNMAP,  10'd0,    10'd0,    1'b1, '{10'd5,    ST_DONE}},
    '{OP_FIND,   10'd0,    10'd0,    1'b0, '{10'd0,    ST_DONE}},
    '{OP_FREE,   10'd0,    10'd0,    1'b1, '{10'd0,    ST_DONE}},
    '{OP_FIND,   10'd0,    10'd0,    1'b0, '{10'd0,    ST_DONE}},
    '{OP_RSVD_A, 10'd1023, 10'd1023, 1'b1, '{10'd0,    ST_DONE}},
    '{OP_RSVD_B, 10'd0,    10'd0,    1'b1, '{10'd0,    ST_DONE}},
    '{OP_RSVD_C, 10'd1023, 10'd1023, 1'b1, '{10'd0,    ST_DONE}},
    '{OP_UNMAP,  10'd1023, 10'd0,    1'b1, '{10'd1023, ST_DONE}},
    '{OP_UNMAP,  10'd1023, 10'd0,    1'b1, '{10'd0,    ST_ABSENT}},
    '{OP_FREE,   10'd0,    10'd1023, 1'b0, '{10'd0,    ST_DONE}},
    '{OP_USE,    10'd0,    10'd1023, 1'b0, '{10'd0,    ST_DONE}},
    '{OP_FIND,   10'd0,    10'd0,    1'b0, '{10'd0,    ST_DONE}},
    '{OP_MAP,    10'd512,  10'd682,  1'b0, '{10'd0,    ST_DONE}},
    '{OP_UNMAP,  10'd512,  10'd0,    1'b0, '{10'd0,    ST_DONE}},
    '{OP_FREE,   10'd0,    10'd1,    1'b0, '{10'd0,    ST_DONE}}
  };

  always #10 clk_i = ~clk_i;

  // Applies one operation to the shadow state and returns the unit's answer.
  function automatic result_t run_page_op(input logic [OP_W-1:0] op,
                                          input logic [PAGE_W-1:0] vp,
                                          input logic [FRAME_W-1:0] fr);
    result_t            r;
    bit                 page_ok;
    bit                 frame_ok;
    logic [FRAME_W-1:0] old;
    r        = '{frame: '0, status: ST_DONE};
    page_ok  = int'(vp) < VIRTUAL_PAGES;
    frame_ok = int'(fr) < PHYSICAL_FRAMES;
    case (op)
      OP_MAP: begin
        if (page_ok && frame_ok) begin
          if (!present_bits[vp]) mapped_pages.push_back(vp);
          used_bits[fr]    = 1'b1;
          page_frame[vp]   = fr;
          present_bits[vp] = 1'b1;
        end
      end
      OP_UNMAP: begin
        if (page_ok && present_bits[vp]) begin
          old = page_frame[vp];
          if (int'(old) < PHYSICAL_FRAMES) used_bits[old] = 1'b0;
          page_frame[vp]   = '0;
          present_bits[vp] = 1'b0;
          for (int k = 0; k < mapped_pages.size(); k++) begin
            if (mapped_pages[k] == vp) begin
              mapped_pages.delete(k);
              break;
            end
          end
          r.frame = old;
        end else begin
          r.status = ST_ABSENT;
        end
      end
      OP_FIND: begin
        r.status = ST_NONE_FREE;
        for (int i = 0; i < PHYSICAL_FRAMES; i++) begin
          if (!used_bits[i]) begin
            r.frame  = FRAME_W'(i);
            r.status = ST_DONE;
            break;
          end
        end
      end
      OP_USE: begin
        if (frame_ok) used_bits[fr] = 1'b1;
      end
      OP_FREE: begin
        if (frame_ok) used_bits[fr] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 5);
  endfunction

  // Sends one operation and records the result it must produce.
  task automatic issue(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] vp,
                       input logic [FRAME_W-1:0] fr, input bit typed,
                       input result_t typed_want, output result_t reply);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    virtual_page_i <= vp;
    frame_number_i <= fr;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    reply = run_page_op(op, vp, fr);
    owed_results.push_back(typed ? typed_want : reply);
  endtask

  // Holds the sender back until every owed result has come out.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus.
  initial begin
    result_t            reply;
    int unsigned        pick;
    logic [PAGE_W-1:0]  vp;
    logic [FRAME_W-1:0] fr;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = OP_FIND;
    virtual_page_i = '0;
    frame_number_i = '0;
    quiet          = 1'b0;
    mismatches     = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[n]) begin
      issue(directed[n].op, directed[n].page, directed[n].frame, directed[n].typed,
            directed[n].want, reply);
    end
    hold_until_drained();

    // Fill the frame bitmap in ascending order with an occasional search,
    // until no free frame is left.
    for (int f = 0; f < PHYSICAL_FRAMES; f++) begin
      if (f % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      issue(OP_USE, PAGE_W'($urandom), FRAME_W'(f), 1'b0, '0, reply);
      if ($urandom_range(0, 15) == 0) issue(OP_FIND, '0, '0, 1'b0, '0, reply);
    end
    issue(OP_FIND, '0, '0, 1'b1, '{frame: '0, status: ST_NONE_FREE}, reply);
    hold_until_drained();

    // Mixed traffic, mostly allocate-then-map and unmap of live pages.
    for (int k = 0; k < RANDOM_ROUNDS; k++) begin
      if (k % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (k == RANDOM_ROUNDS / 2) hold_until_drained();
      pick = $urandom_range(0, 99);
      vp   = PAGE_W'($urandom);
      fr   = FRAME_W'($urandom);
      if (pick < 30) begin
        issue(OP_FIND, vp, fr, 1'b0, '0, reply);
        if (reply.status == ST_DONE) fr = reply.frame;
        issue(OP_MAP, vp, fr, 1'b0, '0, reply);
      end else if (pick < 50) begin
        if (mapped_pages.size() != 0) begin
          vp = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
        end
        issue(OP_UNMAP, vp, fr, 1'b0, '0, reply);
      end else if (pick < 55) begin
        issue(OP_UNMAP, vp, fr, 1'b0, '0, reply);
      end else if (pick < 65) begin
        issue(OP_FIND, vp, fr, 1'b0, '0, reply);
      end else if (pick < 75) begin
        issue(OP_USE, vp, fr, 1'b0, '0, reply);
      end else if (pick < 90) begin
        issue(OP_FREE, vp, fr, 1'b0, '0, reply);
      end else if (pick < 95) begin
        issue(OP_MAP, vp, fr, 1'b0, '0, reply);
      end else begin
        issue(OP_W'($urandom_range(int'(OP_RSVD_A), int'(OP_RSVD_C))), vp, fr, 1'b0, '0,
              reply);
      end
    end

    // Let the last results come out, then watch for strays.
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[page_map_and_frame_bitmap_unit] OK");
    end else begin
      $display("[page_map_and_frame_bitmap_unit] ERROR");
    end
    $finish;
  end

  // Result side: random stalls, every transfer checked against the oldest owed result.
  initial begin
    int unsigned gap;
    result_t     want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = draw_wait();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: frame %0d status %0d", result_frame_o, status_o);
        end
      end else begin
        want = owed_results.pop_front();
        if (result_frame_o !== want.frame || status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected frame %0d status %0d, got frame %0d status %0d",
                     want.frame, want.status, result_frame_o, status_o);
          end
        end
      end
    end
  end

  // Run limit.
  initial begin
    #15_000_000;
    $display("[page_map_and_frame_bitmap_unit] ERROR");
    $finish;
  end

endmodule
